// ----- rtl/socdm_pkg.sv -----
// Shared widths, codes, reset values and types of the strip occupancy monitor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package socdm_pkg;

  // Fixed field widths of the input and result words.
  localparam int CMD_W   = 1;
  localparam int DET_W   = 2;
  localparam int PLN_W   = 1;
  localparam int STRIP_W = 8;
  localparam int SMP_W   = 12;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 40;

  // Configuration register widths and port shape.
  localparam int THR_W      = 12;
  localparam int FRAC_W     = 9;
  localparam int SIU_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Product widths of the occupancy test.
  localparam int LHS_W = CNT_W + SIU_W;
  localparam int RHS_W = TOT_W + FRAC_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_FRACTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIPS_IN_USE = 2'd2;

  // Register reset values.
  localparam logic [THR_W-1:0]  THR_RST  = 12'd300;
  localparam logic [FRAC_W-1:0] FRAC_RST = 9'd26;
  localparam logic [SIU_W-1:0]  SIU_RST  = 9'd256;

  // Default geometry.
  localparam int DEF_DETECTORS = 4;
  localparam int DEF_PLANES    = 2;
  localparam int DEF_STRIPS    = 256;
  localparam int DEF_ADC_BITS  = 12;

  // Requests from the front end to the counter store.
  typedef struct packed {
    logic query;  // read the addressed counter and plane total
    logic inc;    // read, increment and write back both
  } store_req_t;

endpackage

`default_nettype wire

// ----- rtl/socdm_if.sv -----
// Valid/ready channel interfaces for input words and result words.
// Depends on socdm_pkg for the field widths.
`default_nettype none

interface socdm_in_if;
  import socdm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [DET_W-1:0]   detector;
  logic [PLN_W-1:0]   plane;
  logic [STRIP_W-1:0] strip;
  logic [SMP_W-1:0]   sample;
  logic               last_sample;

  modport source (
    output valid, command, detector, plane, strip, sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, command, detector, plane, strip, sample, last_sample,
    output ready
  );
endinterface

interface socdm_out_if;
  import socdm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] hit_count;
  logic [TOT_W-1:0] plane_total;
  logic             bad_strip;

  modport source (
    output valid, hit_count, plane_total, bad_strip,
    input  ready
  );
  modport sink (
    input  valid, hit_count, plane_total, bad_strip,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/socdm_store.sv -----
// Counter store: hit counter memory and plane total memory with read-modify-write,
// one-level forwarding and a clearing pass after reset. Depends on socdm_pkg.
`default_nettype none

module socdm_store #(
  parameter  int DETECTORS = socdm_pkg::DEF_DETECTORS,
  parameter  int PLANES    = socdm_pkg::DEF_PLANES,
  parameter  int STRIPS    = socdm_pkg::DEF_STRIPS,
  localparam int GROUPS    = DETECTORS * PLANES,
  localparam int CELLS     = GROUPS * STRIPS,
  localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  socdm_pkg::store_req_t            req,
  input  logic [CELL_W-1:0]                slot,
  input  logic [GRP_W-1:0]                 grp,
  output logic                             busy,
  output logic [socdm_pkg::CNT_W-1:0]      cnt_q,
  output logic [socdm_pkg::TOT_W-1:0]      tot_q
);
  import socdm_pkg::*;

  logic [CNT_W-1:0] cnt_mem [CELLS];
  logic [TOT_W-1:0] tot_mem [GROUPS];

  logic [CNT_W-1:0]  cnt_rd_r;
  logic [TOT_W-1:0]  tot_rd_r;
  logic              inc_b_r;
  logic [CELL_W-1:0] cell_b_r;
  logic [GRP_W-1:0]  grp_b_r;

  logic              fw_v_r;
  logic [CELL_W-1:0] fw_cell_r;
  logic [GRP_W-1:0]  fw_grp_r;
  logic [CNT_W-1:0]  fw_cnt_r;
  logic [TOT_W-1:0]  fw_tot_r;

  logic              busy_r;
  logic [CELL_W-1:0] clr_r;

  logic              rd_en;
  logic              cnt_we;
  logic              tot_we;
  logic [CELL_W-1:0] cnt_wa;
  logic [GRP_W-1:0]  tot_wa;
  logic [CNT_W-1:0]  cnt_wd;
  logic [TOT_W-1:0]  tot_wd;
  logic [CNT_W-1:0]  cnt_inc;
  logic [TOT_W-1:0]  tot_inc;

  assign rd_en = req.query | req.inc;
  assign busy  = busy_r;

  // The write of the previous word lands on the same edge as this word's read,
  // so the memory returns the old value; take the written one instead.
  assign cnt_q = (fw_v_r && fw_cell_r == cell_b_r) ? fw_cnt_r : cnt_rd_r;
  assign tot_q = (fw_v_r && fw_grp_r == grp_b_r) ? fw_tot_r : tot_rd_r;

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
  assign tot_inc = (tot_q == '1) ? tot_q : tot_q + TOT_W'(1);

  always_comb begin
    if (busy_r) begin
      cnt_we = 1'b1;
      tot_we = (clr_r < CELL_W'(GROUPS));
      cnt_wa = clr_r;
      tot_wa = GRP_W'(clr_r);
      cnt_wd = '0;
      tot_wd = '0;
    end else begin
      cnt_we = inc_b_r;
      tot_we = inc_b_r;
      cnt_wa = cell_b_r;
      tot_wa = grp_b_r;
      cnt_wd = cnt_inc;
      tot_wd = tot_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (rd_en) begin
      cnt_rd_r <= cnt_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_wa] <= tot_wd;
    end
    if (rd_en) begin
      tot_rd_r <= tot_mem[grp];
    end
  end

  always_ff @(posedge clk) begin
    cell_b_r  <= slot;
    grp_b_r   <= grp;
    fw_cell_r <= cell_b_r;
    fw_grp_r  <= grp_b_r;
    fw_cnt_r  <= cnt_inc;
    fw_tot_r  <= tot_inc;
    if (!rst_n) begin
      inc_b_r <= 1'b0;
      fw_v_r  <= 1'b0;
      busy_r  <= 1'b1;
      clr_r   <= '0;
    end else begin
      inc_b_r <= req.inc;
      fw_v_r  <= inc_b_r & ~busy_r;
      if (busy_r) begin
        if (clr_r == CELL_W'(CELLS - 1)) begin
          busy_r <= 1'b0;
        end
        clr_r <= clr_r + CELL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/strip_occupancy_dead_channel_monitor.sv -----
// Top level of the strip occupancy and dead channel monitor.
// Depends on socdm_pkg, socdm_if and socdm_store.
//
//   port     | dir | handshake      | word
//   ---------+-----+----------------+-------------------------------------------------
//   in_ch    | in  | valid / ready  | command, detector, plane, strip, sample, last_sample
//   out_ch   | out | valid / ready  | hit_count, plane_total, bad_strip
//   cfg_*    | in  | cfg_we only    | cfg_idx selects register, cfg_wdata its value
//
// A sample word is taken every cycle unless the clearing pass, a query in flight
// or a full skid word stalls the input; its counter update is a read-modify-write
// of the counter memories in the next cycle, forwarded to a following word. A
// query word holds the input through its memory read, multiply and compare; its
// result waits in the output register, or in the one-word skid behind it while
// that is held, and sample words keep flowing meanwhile unless the skid is full.
// Both memories are cleared entry by entry after reset; the input stalls until
// all DETECTORS*PLANES*STRIPS entries (2048 by default) are done. Writes still land.
`default_nettype none

module strip_occupancy_dead_channel_monitor #(
  parameter int DETECTORS = socdm_pkg::DEF_DETECTORS,
  parameter int PLANES    = socdm_pkg::DEF_PLANES,
  parameter int STRIPS    = socdm_pkg::DEF_STRIPS,
  parameter int ADC_BITS  = socdm_pkg::DEF_ADC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  socdm_in_if.sink                            in_ch,
  socdm_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [socdm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [socdm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import socdm_pkg::*;

  localparam int GROUPS = DETECTORS * PLANES;
  localparam int CELLS  = GROUPS * STRIPS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  // Only the low ADC_BITS of a sample are meaningful.
  localparam logic [SMP_W-1:0] ADC_MASK = SMP_W'((64'd1 << ADC_BITS) - 64'd1);

  // Configuration registers.
  logic [THR_W-1:0]  thr_r;
  logic [FRAC_W-1:0] frac_r;
  logic [SIU_W-1:0]  siu_r;

  // Waveform tracking.
  logic [SMP_W-1:0] base_r;
  logic [SMP_W-1:0] peak_r;
  logic             inside_r;

  // Query pipeline: B holds the memory read, C the products.
  logic             qb_r;
  logic             okb_r;
  logic             qc_r;
  logic [CNT_W-1:0] cnt_c_r;
  logic [TOT_W-1:0] tot_c_r;
  logic [LHS_W-1:0] lhs_c_r;
  logic [RHS_W-1:0] rhs_c_r;

  // Output register and skid word.
  logic             out_v_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [TOT_W-1:0] out_tot_r;
  logic             out_bad_r;
  logic             skid_v_r;
  logic [CNT_W-1:0] skid_cnt_r;
  logic [TOT_W-1:0] skid_tot_r;
  logic             skid_bad_r;

  logic              acc;
  logic              is_query;
  logic              addr_ok;
  logic [SMP_W-1:0]  smp;
  logic [SMP_W-1:0]  peak_eff;
  logic              hit;
  logic [CELL_W-1:0] slot;
  logic [GRP_W-1:0]  grp;
  store_req_t        req;
  logic              busy;
  logic [CNT_W-1:0]  st_cnt;
  logic [TOT_W-1:0]  st_tot;
  logic [CNT_W-1:0]  cnt_b;
  logic [TOT_W-1:0]  tot_b;
  logic              res_bad;
  logic              out_free;

  // ---------------------------------------------------------------------------
  // Input side. A query must find room for its result, so at most one query is
  // in flight and the skid word is empty when a new word is taken.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = ~busy & ~qb_r & ~qc_r & ~skid_v_r;
  assign acc         = in_ch.valid & in_ch.ready;
  assign is_query    = (in_ch.command == CMD_QUERY);
  assign smp         = in_ch.sample & ADC_MASK;

  // Addresses outside the configured geometry update nothing and read as zero.
  assign addr_ok = (32'(in_ch.detector) < 32'(DETECTORS)) &&
                   (32'(in_ch.plane) < 32'(PLANES)) &&
                   (32'(in_ch.strip) < 32'(STRIPS));
  assign grp  = GRP_W'(32'(in_ch.detector) * 32'(PLANES) + 32'(in_ch.plane));
  assign slot = CELL_W'((32'(in_ch.detector) * 32'(PLANES) + 32'(in_ch.plane)) *
                        32'(STRIPS) + 32'(in_ch.strip));

  // The peak includes this sample. A first sample is its own baseline and peak,
  // so a one-sample waveform never counts as a hit.
  assign peak_eff = (smp > peak_r) ? smp : peak_r;
  assign hit      = inside_r && ((peak_eff - base_r) > thr_r);

  assign req.query = acc & is_query & addr_ok;
  assign req.inc   = acc & ~is_query & in_ch.last_sample & addr_ok & hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RST;
      frac_r <= FRAC_RST;
      siu_r  <= SIU_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HIT_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        REG_BAD_FRACTION:  frac_r <= cfg_wdata[FRAC_W-1:0];
        REG_STRIPS_IN_USE: siu_r  <= cfg_wdata[SIU_W-1:0];
        default:           ;
      endcase
    end
  end

  // Waveform state follows sample words only; a query leaves it alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      peak_r   <= '0;
      inside_r <= 1'b0;
    end else if (acc && !is_query) begin
      if (!inside_r) begin
        base_r <= smp;
        peak_r <= smp;
      end else begin
        peak_r <= peak_eff;
      end
      inside_r <= ~in_ch.last_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Counter store: both memories and their read-modify-write path.
  // ---------------------------------------------------------------------------
  socdm_store #(
    .DETECTORS (DETECTORS),
    .PLANES    (PLANES),
    .STRIPS    (STRIPS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .slot  (slot),
    .grp   (grp),
    .busy  (busy),
    .cnt_q (st_cnt),
    .tot_q (st_tot)
  );

  // ---------------------------------------------------------------------------
  // Query pipeline. The occupancy test compares count*strips_in_use*256 with
  // total*fraction; the products are registered before the compare.
  // ---------------------------------------------------------------------------
  assign cnt_b = okb_r ? st_cnt : '0;
  assign tot_b = okb_r ? st_tot : '0;

  always_ff @(posedge clk) begin
    okb_r   <= addr_ok;
    cnt_c_r <= cnt_b;
    tot_c_r <= tot_b;
    lhs_c_r <= LHS_W'(cnt_b) * LHS_W'(siu_r);
    rhs_c_r <= RHS_W'(tot_b) * RHS_W'(frac_r);
    if (!rst_n) begin
      qb_r <= 1'b0;
      qc_r <= 1'b0;
    end else begin
      qb_r <= acc & is_query;
      qc_r <= qb_r;
    end
  end

  assign res_bad = ({lhs_c_r, 8'h00} < rhs_c_r);

  // ---------------------------------------------------------------------------
  // Output register with a one-word skid. The skid word only fills when a
  // result arrives while the output register is held.
  // ---------------------------------------------------------------------------
  assign out_free = ~out_v_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= qc_r;
      end else begin
        out_v_r  <= qc_r;
      end
    end else if (qc_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_cnt_r  <= skid_cnt_r;
        out_tot_r  <= skid_tot_r;
        out_bad_r  <= skid_bad_r;
        skid_cnt_r <= cnt_c_r;
        skid_tot_r <= tot_c_r;
        skid_bad_r <= res_bad;
      end else begin
        out_cnt_r <= cnt_c_r;
        out_tot_r <= tot_c_r;
        out_bad_r <= res_bad;
      end
    end else if (qc_r) begin
      skid_cnt_r <= cnt_c_r;
      skid_tot_r <= tot_c_r;
      skid_bad_r <= res_bad;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.hit_count   = out_cnt_r;
  assign out_ch.plane_total = out_tot_r;
  assign out_ch.bad_strip   = out_bad_r;

endmodule

`default_nettype wire

// ----- rtl/socdm_chk.sv -----
// Port-level checker for the strip occupancy monitor and its bind statement.
// Depends on socdm_pkg and the top level strip_occupancy_dead_channel_monitor.
`default_nettype none

module socdm_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [socdm_pkg::CMD_W-1:0]   in_command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [socdm_pkg::CNT_W-1:0]   out_hit_count,
  input logic [socdm_pkg::TOT_W-1:0]   out_plane_total,
  input logic                          out_bad_strip
);
  import socdm_pkg::*;

  // An accepted query shows a result word once it has passed the memory read, product and output registers.
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_QUERY) |-> ##3 out_valid)
    else $error("query word produced no result");

  // A plane total covers every strip count in it, and a flagged strip needs a nonzero plane total.
  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_plane_total >= TOT_W'(out_hit_count)) &&
                  (!out_bad_strip || out_plane_total != '0))
    else $error("result word inconsistent");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_hit_count) && $stable(out_plane_total) &&
                                   $stable(out_bad_strip)))
    else $error("result word changed while stalled");

endmodule

bind strip_occupancy_dead_channel_monitor socdm_chk u_socdm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit_count   (out_ch.hit_count),
  .out_plane_total (out_ch.plane_total),
  .out_bad_strip   (out_ch.bad_strip)
);

`default_nettype wire
